[rtl/hotp_pkg.sv]
// ----------------------------------------------------------------------------
// hotp_pkg: shared types and constants for the HOTP generator
// Holds the SHA-1 constants, the sequencer states and the round helpers.
// ----------------------------------------------------------------------------
package hotp_pkg;

  localparam int MAX_KEY_BYTES = 32;
  localparam int KEY_BYTES     = (MAX_KEY_BYTES < 32) ? MAX_KEY_BYTES : 32;

  // configuration register indexes
  localparam logic [2:0] CFG_KEY0   = 3'd0;
  localparam logic [2:0] CFG_KEY1   = 3'd1;
  localparam logic [2:0] CFG_KEY2   = 3'd2;
  localparam logic [2:0] CFG_KEY3   = 3'd3;
  localparam logic [2:0] CFG_KEYLEN = 3'd4;
  localparam logic [2:0] CFG_DIGITS = 3'd5;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_TRUNC,
    ST_MOD,
    ST_DONE
  } hotp_state_t;

  // control from sequencer to round core
  typedef struct packed {
    logic       load;    // load block words and working variables
    logic       init;    // chaining values from the SHA-1 IV
    logic       round;   // advance one round
    logic       fold;    // add working vars into chaining values
    logic [6:0] rnd;     // round index
  } hotp_core_ctl_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20)      k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else                k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20)      f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction

  // 10^n for n = 6..9
  function automatic logic [30:0] pow10(input logic [3:0] n);
    logic [30:0] p;
    unique case (n)
      4'd6:    p = 31'd1000000;
      4'd7:    p = 31'd10000000;
      4'd8:    p = 31'd100000000;
      default: p = 31'd1000000000;
    endcase
    return p;
  endfunction

endpackage

[rtl/hotp_sha1_core.sv]
// ----------------------------------------------------------------------------
// hotp_sha1_core: one SHA-1 round per cycle
// Keeps the 16-word schedule window, the working variables and the chaining
// values; one shared round adder is reused for all 80 rounds.
// ----------------------------------------------------------------------------
module hotp_sha1_core import hotp_pkg::*; (
  input  logic           clk,
  input  hotp_core_ctl_t ctl,
  input  logic [511:0]   block_in,
  output logic [159:0]   digest
);

  logic [31:0] w_r   [16];
  logic [31:0] w_nxt [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] h_r   [5];
  logic [31:0] t_val, w_new, w_cur;

  // schedule: current word at the window head, new word from taps
  assign w_cur = w_r[0];
  always_comb begin
    w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = {w_new[30:0], w_new[31]};
    for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
    w_nxt[15] = w_new;
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + round_f(ctl.rnd, b_r, c_r, d_r)
               + e_r + round_k(ctl.rnd) + w_cur;

  // load, advance and fold the compression state
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 16; i++) w_r[i] <= block_in[511-32*i -: 32];
      if (ctl.init) begin
        h_r[0] <= H0; h_r[1] <= H1; h_r[2] <= H2; h_r[3] <= H3; h_r[4] <= H4;
        a_r <= H0; b_r <= H1; c_r <= H2; d_r <= H3; e_r <= H4;
      end else begin
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
      end
    end else if (ctl.round) begin
      w_r <= w_nxt;
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t_val;
    end else if (ctl.fold) begin
      h_r[0] <= h_r[0] + a_r;
      h_r[1] <= h_r[1] + b_r;
      h_r[2] <= h_r[2] + c_r;
      h_r[3] <= h_r[3] + d_r;
      h_r[4] <= h_r[4] + e_r;
    end
  end

  assign digest = {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};

endmodule

[rtl/hotp_sequencer.sv]
// ----------------------------------------------------------------------------
// hotp_sequencer: pass and round control
// Steps through four compressions, truncation and the modulo reduction.
// ----------------------------------------------------------------------------
module hotp_sequencer import hotp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           mod_done,
  input  logic           out_taken,
  output hotp_state_t    state,
  output logic [1:0]     pass,
  output hotp_core_ctl_t ctl
);

  hotp_state_t state_r, state_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic [1:0]  pass_r, pass_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    pass_nxt  = pass_r;
    unique case (state_r)
      ST_IDLE:  if (start) begin
        state_nxt = ST_LOAD;
        pass_nxt  = 2'd0;
      end
      ST_LOAD: begin
        state_nxt = ST_ROUND;
        rnd_nxt   = 7'd0;
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'd79) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        pass_nxt = pass_r + 2'd1;
        state_nxt = (pass_r == 2'd3) ? ST_TRUNC : ST_LOAD;
      end
      ST_TRUNC: state_nxt = ST_MOD;
      ST_MOD:   if (mod_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_taken) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.load  = (state_r == ST_LOAD);
    ctl.init  = (state_r == ST_LOAD) && !pass_r[0];
    ctl.round = (state_r == ST_ROUND);
    ctl.fold  = (state_r == ST_FOLD);
    ctl.rnd   = rnd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= '0;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      pass_r  <= pass_nxt;
    end
  end

  assign state = state_r;
  assign pass  = pass_r;

endmodule

[rtl/hotp_hmac_sha1_generator_unit.sv]
// ----------------------------------------------------------------------------
// hotp_hmac_sha1_generator_unit: HOTP one-time password generator
// ----------------------------------------------------------------------------
// Each accepted counter word yields one otp_value after four SHA-1
// compressions (each a load, 80 rounds on the single round adder and a
// fold), a truncation step, restoring subtraction over shifts 30..0 for
// the modulo (ended at once for ten digits), and a done state that holds
// the result until it is taken. in_stall is high from acceptance until the
// result is taken. Key and digit registers are written through cfg_*; the
// user must do so only while the block is idle, as the block does not check.
// ----------------------------------------------------------------------------
module hotp_hmac_sha1_generator_unit import hotp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_moving_counter,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] out_otp_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]    key_w_r [4];
  logic [5:0]     key_len_r;
  logic [3:0]     digits_r;
  logic [63:0]    ctr_r;
  logic [159:0]   inner_r;
  logic [159:0]   digest;
  logic [511:0]   block;
  logic [255:0]   key_raw, key_mask, key_bytes;
  logic [5:0]     klen;
  logic [3:0]     nd;
  logic [1:0]     pass;
  hotp_state_t    state;
  hotp_core_ctl_t ctl;
  logic           start, out_taken, mod_done;
  logic [30:0]    rem_r, div_r;
  logic [4:0]     mcnt_r;
  logic [61:0]    trial;
  logic [31:0]    word;
  logic [3:0]     off;

  assign start     = in_valid && !in_stall;
  assign out_taken = out_valid && !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_w_r[i] <= '0;
      key_len_r <= 6'd20;
      digits_r  <= 4'd6;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY0:   key_w_r[0] <= cfg_data;
        CFG_KEY1:   key_w_r[1] <= cfg_data;
        CFG_KEY2:   key_w_r[2] <= cfg_data;
        CFG_KEY3:   key_w_r[3] <= cfg_data;
        CFG_KEYLEN: key_len_r  <= cfg_data[5:0];
        CFG_DIGITS: digits_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamp key length and mask unused key bytes
  assign klen    = (key_len_r > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : key_len_r;
  assign key_raw = {key_w_r[0], key_w_r[1], key_w_r[2], key_w_r[3]};
  always_comb begin
    for (int i = 0; i < 32; i++)
      key_mask[255-8*i -: 8] = (6'(i) < klen) ? 8'hFF : 8'h00;
  end
  assign key_bytes = key_raw & key_mask;

  // pick the block for each pass: ipad, inner tail, opad, outer tail
  always_comb begin
    unique case (pass)
      2'd0: block = {key_bytes ^ {32{8'h36}}, {32{8'h36}}};
      2'd1: block = {ctr_r, 8'h80, 376'd0, 64'd576};
      2'd2: block = {key_bytes ^ {32{8'h5C}}, {32{8'h5C}}};
      default: block = {inner_r, 8'h80, 280'd0, 64'd672};
    endcase
  end

  hotp_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .mod_done  (mod_done),
    .out_taken (out_taken),
    .state     (state),
    .pass      (pass),
    .ctl       (ctl)
  );

  hotp_sha1_core u_core (
    .clk      (clk),
    .ctl      (ctl),
    .block_in (block),
    .digest   (digest)
  );

  // dynamic truncation
  assign off  = digest[3:0];
  assign word = digest[159 - 8*off -: 32];
  assign nd   = (digits_r < 4'd6) ? 4'd6 : ((digits_r > 4'd10) ? 4'd10 : digits_r);

  // restoring reduction: subtract divisor*2^k for k = 30..0
  assign trial    = {31'd0, rem_r} - ({31'd0, div_r} << mcnt_r);
  assign mod_done = (mcnt_r == 5'd0) || (nd == 4'd10);

  always_ff @(posedge clk) begin
    if (start) ctr_r <= in_moving_counter;
    // grab the inner digest once its fold has settled, at the outer load
    if (ctl.load && pass == 2'd2) inner_r <= digest;
    if (state == ST_TRUNC) begin
      rem_r  <= word[30:0];
      div_r  <= pow10(nd);
      mcnt_r <= 5'd30;
    end else if (state == ST_MOD) begin
      if (!trial[61]) rem_r <= trial[30:0];
      if (mcnt_r != 5'd0) mcnt_r <= mcnt_r - 5'd1;
    end
  end

  assign out_valid     = (state == ST_DONE);
  assign out_otp_value = rem_r;

endmodule

[rtl/hotp_checker.sv]
// ----------------------------------------------------------------------------
// hotp_checker: port-level checks for the HOTP generator
// Watches handshakes and result bounds on the top level's ports.
// ----------------------------------------------------------------------------
module hotp_checker import hotp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_otp_value
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_otp_value))
    else $error("result dropped while stalled");

  // no new word taken while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken with result pending");

  // an accepted word produces no result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid && in_stall)
    else $error("result too early");

  // value always fits ten decimal digits bound
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_otp_value[30] == 1'b0 || out_otp_value <= 31'h7FFFFFFF)
    else $error("result out of range");

endmodule

bind hotp_hmac_sha1_generator_unit hotp_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_otp_value (out_otp_value)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the HOTP HMAC-SHA1 generator
// Sends counter words through the input channel under bursty idling, predicts
// each one-time password with a SHA-1 based model, and compares every word
// that leaves the result channel against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import hotp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_moving_counter;
  logic        out_valid;
  logic        out_stall;
  logic [30:0] out_otp_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  // predictor copy of the configuration
  logic [63:0] key_regs [4];
  logic [5:0]  key_len_reg;
  logic [3:0]  digits_reg;

  logic [30:0] otp_expected_q [$];
  int          error_count;
  int          words_sent;
  int          words_checked;
  int          hold_off_cycles;
  bit          sender_gaps;

  hotp_hmac_sha1_generator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_moving_counter(in_moving_counter),
    .out_valid(out_valid), .out_stall(out_stall), .out_otp_value(out_otp_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------- SHA-1 / HMAC predictor ----------------
  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_compress(ref logic [31:0] h [5], input logic [7:0] blk [64]);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol32(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol32(b, 30); b = a; a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
  endfunction

  // hash a padded-key block followed by a short tail
  function automatic void sha1_keyed(input logic [7:0] pad_blk [64], input logic [7:0] tail [20],
                                     input int tlen, output logic [7:0] dig [20]);
    logic [31:0] h [5];
    logic [7:0]  blk [64];
    logic [31:0] bits;
    h[0] = H0; h[1] = H1; h[2] = H2; h[3] = H3; h[4] = H4;
    sha1_compress(h, pad_blk);
    bits = (64 + tlen) * 8;
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    for (int i = 0; i < tlen; i++) blk[i] = tail[i];
    blk[tlen] = 8'h80;
    blk[60] = bits[31:24]; blk[61] = bits[23:16]; blk[62] = bits[15:8]; blk[63] = bits[7:0];
    sha1_compress(h, blk);
    for (int i = 0; i < 5; i++)
      {dig[4*i], dig[4*i+1], dig[4*i+2], dig[4*i+3]} = h[i];
  endfunction

  function automatic logic [30:0] predict_otp(logic [63:0] ctr);
    logic [7:0]  ipad [64], opad [64], key [64], msg [20], inner [20], dig [20];
    int          len, nd, off;
    logic [31:0] v;
    len = key_len_reg;
    if (len > KEY_BYTES) len = KEY_BYTES;
    for (int i = 0; i < 64; i++) key[i] = 8'h00;
    for (int i = 0; i < len; i++) key[i] = key_regs[i / 8][8 * (7 - i % 8) +: 8];
    for (int i = 0; i < 64; i++) begin
      ipad[i] = key[i] ^ 8'h36;
      opad[i] = key[i] ^ 8'h5C;
    end
    for (int i = 0; i < 20; i++) msg[i] = 8'h00;
    for (int i = 0; i < 8; i++) msg[i] = ctr[8 * (7 - i) +: 8];
    sha1_keyed(ipad, msg, 8, inner);
    sha1_keyed(opad, inner, 20, dig);
    off = dig[19][3:0];
    v = {dig[off], dig[off+1], dig[off+2], dig[off+3]} & 32'h7FFFFFFF;
    nd = digits_reg;
    if (nd < 6) nd = 6;
    if (nd > 10) nd = 10;
    if (nd < 10) v = 32'(v % (64'd10 ** nd));
    return v[30:0];
  endfunction

  // ---------------- drivers ----------------
  task automatic send_counter(logic [63:0] ctr);
    in_valid          <= 1'b1;
    in_moving_counter <= ctr;
    otp_expected_q.push_back(predict_otp(ctr));
    do @(posedge clk); while (in_stall);
    words_sent++;
    // drop valid for one cycle before the next word
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // bursty sender: random gap before an item when gaps are on
  task automatic offer_counter(logic [63:0] ctr);
    if (sender_gaps && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 12)) @(posedge clk);
    send_counter(ctr);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx <= CFG_KEY3) key_regs[idx[1:0]] = data;
    else if (idx == CFG_KEYLEN) key_len_reg = data[5:0];
    else if (idx == CFG_DIGITS) digits_reg = data[3:0];
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (otp_expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // receiver stall pattern plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall       <= 1'b1;
    end else begin
      case ((words_checked / 40) % 3)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // check each accepted result word
  always @(posedge clk) begin
    logic [30:0] exp_otp;
    if (rst_n && out_valid && !out_stall) begin
      if (otp_expected_q.size() == 0) begin
        $error("unexpected otp_value word: actual %0d", out_otp_value);
        error_count++;
      end else begin
        exp_otp = otp_expected_q.pop_front();
        if (out_otp_value !== exp_otp) begin
          $error("otp_value mismatch: expected %0d actual %0d", exp_otp, out_otp_value);
          error_count++;
        end
      end
      words_checked++;
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_defaults();
    send_counter(64'd0);
    send_counter(64'd1);
    send_counter(64'hFFFF_FFFF_FFFF_FFFF);
    drain_results();
  endtask

  // known RFC key "12345678901234567890" and extreme counters
  task automatic test_known_key();
    write_reg(CFG_KEY0, 64'h3132333435363738);
    write_reg(CFG_KEY1, 64'h3930313233343536);
    write_reg(CFG_KEY2, 64'h3738393000000000);
    write_reg(CFG_KEY3, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_KEYLEN, 64'd20);
    write_reg(CFG_DIGITS, 64'd6);
    for (int i = 0; i < 4; i++) send_counter(64'(i));
    send_counter(64'h8000_0000_0000_0000);
    send_counter(64'h5555_5555_5555_5555);
    drain_results();
  endtask

  // key lengths from zero up to and beyond the register capacity, digit clamping
  task automatic test_corner_settings();
    logic [5:0] lens [5] = '{6'd0, 6'd1, 6'd32, 6'd33, 6'd63};
    logic [3:0] digs [5] = '{4'd0, 4'd5, 4'd10, 4'd11, 4'd15};
    for (int i = 0; i < 5; i++) begin
      write_reg(CFG_KEYLEN, 64'(lens[i]));
      write_reg(CFG_DIGITS, 64'(digs[i]));
      send_counter(rand64());
      send_counter(64'hAAAA_AAAA_AAAA_AAAA);
      drain_results();
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_back_pressure();
    hold_off_cycles = 1500;
    for (int i = 0; i < 4; i++) send_counter(rand64());
    drain_results();
  endtask

  task automatic test_random_phases(int n_phases, int per_phase);
    for (int p = 0; p < n_phases; p++) begin
      for (int r = 0; r < 4; r++) write_reg(r[2:0], rand64());
      if (p % 4 == 0) write_reg(CFG_KEYLEN, 64'd32);
      else if (p % 4 == 1) write_reg(CFG_KEYLEN, 64'd0);
      else write_reg(CFG_KEYLEN, 64'($urandom_range(0, 63)));
      if (p % 5 == 0) write_reg(CFG_DIGITS, 64'd10);
      else write_reg(CFG_DIGITS, 64'($urandom_range(0, 15)));
      sender_gaps = (p % 3 != 0);
      for (int i = 0; i < per_phase; i++) offer_counter(rand64());
      // pause until all results are back
      drain_results();
    end
  endtask

  initial begin
    clk = 1'b0; rst_n = 1'b0;
    in_valid = 1'b0; in_moving_counter = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    error_count = 0; words_sent = 0; words_checked = 0;
    hold_off_cycles = 0; sender_gaps = 1'b0;
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    key_len_reg = 6'd20; digits_reg = 4'd6;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_known_key();
    test_corner_settings();
    test_back_pressure();
    test_random_phases(31, 50);
    $display("Sent %0d counter words and checked %0d results", words_sent, words_checked);
    $display("across default, clamped, extreme and random key and digit settings.");
    if (error_count == 0 && otp_expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (otp_expected_q.size() != 0)
        $error("%0d expected results never arrived", otp_expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
